// ===== hw/rtl/wgm_pkg.sv =====
`default_nettype none

package wgm_pkg;

  // Pattern storage held by the two pattern word registers
  localparam int WordBytes = 16;
  localparam int PatternBits = WordBytes * 8;
  localparam int PatternMaxDefault = 16;

  // Wildcard bytes
  localparam logic [7:0] AnyOne = 8'h3F;
  localparam logic [7:0] AnyRun = 8'h2A;

  // Configuration register indexes
  localparam int CfgIndexWidth = 8;
  localparam logic [CfgIndexWidth-1:0] CfgPatternWord0 = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CfgPatternWord1 = 8'd1;
  localparam logic [CfgIndexWidth-1:0] CfgPatternLength = 8'd2;
  localparam logic [CfgIndexWidth-1:0] CfgCaseSensitive = 8'd3;

  // Queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCountWidth = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] text_char;
    logic       char_present;
    logic       end_of_string;
  } wgm_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wgm_q_status_t;

  // ASCII uppercasing, letters a..z only
  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wgm_front.sv =====
`default_nettype none

module wgm_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         text_char,
  input  wire logic               char_present,
  input  wire logic               end_of_string,
  input  wgm_pkg::wgm_q_status_t  q_status,
  output logic                    push,
  output wgm_pkg::wgm_item_t      push_item
);
  import wgm_pkg::*;

  logic      front_valid;
  wgm_item_t front_item;
  logic      accept;

  // Hold one transaction; stall only while it cannot enter the queue
  assign in_stall  = front_valid && q_status.full;
  assign accept    = in_valid && !in_stall;
  assign push      = front_valid && !q_status.full;
  assign push_item = front_item;

  // Idle items (no byte, no end mark) are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= char_present || end_of_string;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item.text_char     <= text_char;
      front_item.char_present  <= char_present;
      front_item.end_of_string <= end_of_string;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wgm_queue.sv =====
`default_nettype none

module wgm_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wgm_pkg::wgm_item_t      push_item,
  input  wire logic               pop,
  output wgm_pkg::wgm_item_t      pop_item,
  output wgm_pkg::wgm_q_status_t  q_status
);
  import wgm_pkg::*;

  wgm_item_t                  entries [QueueDepth];
  logic [QueuePtrWidth-1:0]   wr_ptr;
  logic [QueuePtrWidth-1:0]   rd_ptr;
  logic [QueueCountWidth-1:0] count;

  assign q_status.full  = (count == QueueCountWidth'(QueueDepth));
  assign q_status.empty = (count == '0);
  assign pop_item       = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wgm_back.sv =====
`default_nettype none

module wgm_back #(
  parameter int PatternMax = wgm_pkg::PatternMaxDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            restart,
  input  wire logic [wgm_pkg::PatternBits-1:0] pattern,
  input  wire logic [4:0]                      len_eff,
  input  wire logic                            case_sensitive,
  input  wgm_pkg::wgm_item_t                   pop_item,
  input  wgm_pkg::wgm_q_status_t               q_status,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 matched
);
  import wgm_pkg::*;

  localparam int Positions = PatternMax + 1;

  logic [7:0]           pbyte [PatternMax];
  logic [PatternMax-1:0] star_v;
  logic [PatternMax-1:0] hit_v;
  logic [Positions-1:0] reach [Positions];
  logic [Positions-1:0] accept_mask;
  logic [Positions-1:0] active;
  logic                 fresh;
  logic [Positions-1:0] cur;
  logic [Positions-1:0] step_raw;
  logic [Positions-1:0] closed;
  logic [Positions-1:0] nxt;
  logic                 match_now;

  // Pattern bytes beyond the two words read as zero
  for (genvar g = 0; g < PatternMax; g++) begin : g_pbyte
    if (g < WordBytes) begin : g_word
      assign pbyte[g] = pattern[g*8 +: 8];
    end else begin : g_none
      assign pbyte[g] = 8'h00;
    end
  end

  // Per-position decode against the current byte
  always_comb begin
    logic [7:0] c;
    logic       eq;
    c = pop_item.text_char;
    for (int i = 0; i < PatternMax; i++) begin
      if (case_sensitive) begin
        eq = (pbyte[i] == c);
      end else begin
        eq = (upcase(pbyte[i]) == upcase(c));
      end
      star_v[i] = (i < int'(len_eff)) && (pbyte[i] == AnyRun);
      hit_v[i]  = (i < int'(len_eff)) && (pbyte[i] != AnyRun) &&
                  ((pbyte[i] == AnyOne) || eq);
    end
  end

  // Positions reachable from each position over a run of stars
  always_comb begin
    for (int i = 0; i < Positions; i++) begin
      reach[i] = '0;
      for (int k = 0; k < Positions; k++) begin
        if (k == i) begin
          reach[i][k] = 1'b1;
        end else if (k > i) begin
          reach[i][k] = reach[i][k-1] && star_v[k-1];
        end
      end
      accept_mask[i] = (i == int'(len_eff));
    end
  end

  // One step of the active set
  always_comb begin
    cur = fresh ? reach[0] : active;
    step_raw = '0;
    for (int i = 0; i < PatternMax; i++) begin
      if (cur[i] && star_v[i]) begin
        step_raw[i] = 1'b1;
      end
      if (cur[i] && hit_v[i]) begin
        step_raw[i+1] = 1'b1;
      end
    end
    closed = '0;
    for (int i = 0; i < Positions; i++) begin
      if (step_raw[i]) begin
        closed = closed | reach[i];
      end
    end
    nxt = pop_item.char_present ? closed : cur;
    match_now = |(nxt & accept_mask);
  end

  // Take an item unless its result would land on a stalled output
  assign pop = !q_status.empty &&
               (!pop_item.end_of_string || !out_valid || !out_stall);

  // Active set; fresh stands for the start set of the live pattern
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b1;
    end else if (restart) begin
      fresh <= 1'b1;
    end else if (pop) begin
      fresh <= pop_item.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !pop_item.end_of_string) begin
      active <= nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && pop_item.end_of_string) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_item.end_of_string) begin
      matched <= match_now;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_stall    text_char, char_present, end_of_string
// output   out        out_valid / out_stall  matched
// config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One text byte per cycle is taken while in_stall is low and is applied to the
// active position set, which the back end updates as it pops each byte.
// out_valid rises once the end-of-string item has been popped from the queue.
// rst is synchronous; it clears control state and loads the register defaults.
// An output stall holds the result and stops the back end only at the next
// end of string; the front keeps filling the four-entry queue meanwhile.
`default_nettype none

module wildcard_glob_matcher #(
  parameter int PatternMax = wgm_pkg::PatternMaxDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        text_char,
  input  wire logic                              char_present,
  input  wire logic                              end_of_string,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   matched,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wgm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [63:0]                       cfg_data
);
  import wgm_pkg::*;

  localparam int LenCap = (PatternMax < WordBytes) ? PatternMax : WordBytes;

  logic [63:0]   pattern_word0;
  logic [63:0]   pattern_word1;
  logic [4:0]    pattern_length;
  logic          case_sensitive;
  logic [4:0]    len_eff;
  logic          cfg_write;
  logic          restart;
  logic          push;
  wgm_item_t     push_item;
  logic          pop;
  wgm_item_t     pop_item;
  wgm_q_status_t q_status;

  // Configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word0  <= '0;
      pattern_word1  <= '0;
      pattern_length <= '0;
      case_sensitive <= 1'b1;
      restart        <= 1'b0;
    end else begin
      restart <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          CfgPatternWord0: begin
            pattern_word0 <= cfg_data;
            restart       <= 1'b1;
          end
          CfgPatternWord1: begin
            pattern_word1 <= cfg_data;
            restart       <= 1'b1;
          end
          CfgPatternLength: begin
            pattern_length <= cfg_data[4:0];
            restart        <= 1'b1;
          end
          CfgCaseSensitive: begin
            case_sensitive <= cfg_data[0];
            restart        <= 1'b1;
          end
          default: begin
            restart <= 1'b0;
          end
        endcase
      end
    end
  end

  // Length in use saturates to the smaller of PatternMax and the pattern word bytes
  assign len_eff = (pattern_length > 5'(LenCap)) ? 5'(LenCap) : pattern_length;

  wgm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_char     (text_char),
    .char_present  (char_present),
    .end_of_string (end_of_string),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  wgm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  wgm_back #(
    .PatternMax (PatternMax)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .restart        (restart),
    .pattern        ({pattern_word1, pattern_word0}),
    .len_eff        (len_eff),
    .case_sensitive (case_sensitive),
    .pop_item       (pop_item),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .matched        (matched)
  );

`ifndef SYNTH
  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full))
    else $error("queue written while full");

  // Queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_status.empty))
    else $error("queue read while empty");

  // A new result only follows an end-of-string transaction leaving the queue
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && pop_item.end_of_string))
    else $error("result without end of string");
`endif

endmodule

`default_nettype wire
